// File: hdl/kbs_pkg.sv
// Package for the kanji bitmap set: sizes, operation and status codes,
// and the command, result and control types shared by the modules.
// Depends on nothing.
package kbs_pkg;

    localparam int ROWS  = 69;
    localparam int CELLS = 94;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COUNT_W = 13;
    localparam int CODE_W  = 16;

    localparam logic [15:0] BASE_RESET = 16'h3021;
    localparam logic [15:0] TEXT_FLOOR = 16'h3000;
    localparam logic [7:0]  EUC_LOW    = 8'hA1;
    localparam logic [7:0]  EUC_HIGH   = 8'hFE;

    localparam logic [2:0] OP_ADD      = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_QUERY    = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_ADD_EUC  = 3'd4;
    localparam logic [2:0] OP_ADD_TEXT = 3'd5;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_CHANGE = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_EUC   = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] jis_code;
        logic [7:0]  euc_lead;
        logic [7:0]  euc_trail;
    } kbs_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               present;
        logic [COUNT_W-1:0] member_count;
        logic [15:0]        decoded_code;
    } kbs_result_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic update;
    } kbs_ctrl_t;

endpackage

// File: hdl/kanji_bitmap_set_unit.sv
// Top level of the kanji bitmap set: controller plus datapath.
// Depends on kbs_pkg, kbs_ctrl and kbs_datapath.
//
//   channel   ports                       transfer
//   command   start, busy, cmd            start high while busy low
//   result    done, result                done high for one cycle
//   config    cfg_wr_en, cfg_wr_data      cfg_wr_en high, no wait
//
// Between acceptance and the done strobe lie the load, row read and row
// update steps around the bitmap memory.
// A new transaction is accepted in the cycle that shows the done strobe.
// Reset empties the set by clearing the per-row valid flags; no sweep runs.
// The clear operation empties the set in one update step the same way.
// The receiver cannot stall; each result is shown for exactly one cycle.
module kanji_bitmap_set_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  kbs_pkg::kbs_cmd_t    cmd,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    output logic                 done,
    output kbs_pkg::kbs_result_t result
);

    kbs_pkg::kbs_ctrl_t ctrl;

    kbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    kbs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .result      (result)
    );

    // An accepted transaction yields its result after the load, row read and row update steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction did not complete in three cycles");

    // A result only follows a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    // The unit only becomes busy on an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without start");

    // The control steps are mutually exclusive.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.read, ctrl.update}))
        else $error("controller issued overlapping steps");

endmodule

// File: hdl/kbs_ctrl.sv
// Controller of the kanji bitmap set: sequences load, row read and
// row update for one transaction at a time.
// Depends on kbs_pkg.
module kbs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output kbs_pkg::kbs_ctrl_t ctrl
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        ctrl.load   = 1'b0;
        ctrl.read   = 1'b0;
        ctrl.update = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctrl.read  = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: hdl/kbs_datapath.sv
// Datapath of the kanji bitmap set: code decode and range check, the
// row-wide bitmap memory with per-row valid flags, member count and result.
// Depends on kbs_pkg.
module kbs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kbs_pkg::kbs_ctrl_t            ctrl,
    input  kbs_pkg::kbs_cmd_t             cmd,
    input  logic                          cfg_wr_en,
    input  logic [15:0]                   cfg_wr_data,
    output logic                          done,
    output kbs_pkg::kbs_result_t          result
);

    // Configuration.
    logic [15:0] base_reg;

    // Decoded transaction.
    logic [2:0]                   op_reg;
    logic [15:0]                  code_reg;
    logic                         euc_ok_reg;
    logic                         loc_ok_reg;
    logic                         low_text_reg;
    logic [kbs_pkg::ROW_W-1:0]    row_reg;
    logic [kbs_pkg::CELL_W-1:0]   cell_reg;

    // Bitmap storage: one word per row; a row never written reads as zero.
    logic [kbs_pkg::CELLS-1:0]    member_mem [kbs_pkg::ROWS];
    logic [kbs_pkg::ROWS-1:0]     row_valid_reg;
    logic [kbs_pkg::CELLS-1:0]    rd_row_reg;
    logic                         rd_valid_reg;

    logic [kbs_pkg::COUNT_W-1:0]  count_reg;
    logic                         done_reg;
    kbs_pkg::kbs_result_t         result_reg;

    // Load-side decode.
    logic [15:0] code_sel;
    logic [15:0] offset;
    logic        euc_ok;
    logic        loc_ok;

    // Update-side decision.
    logic                         cur_bit;
    logic                         set_bit;
    logic                         clr_bit;
    logic [1:0]                   status_next;
    logic                         present_next;
    logic [15:0]                  decoded_next;
    logic [kbs_pkg::CELLS-1:0]    new_row;
    logic [kbs_pkg::COUNT_W-1:0]  count_next;

    always_comb
    begin
        euc_ok = (cmd.euc_lead inside {[kbs_pkg::EUC_LOW:kbs_pkg::EUC_HIGH]})
              && (cmd.euc_trail inside {[kbs_pkg::EUC_LOW:kbs_pkg::EUC_HIGH]});
        if (cmd.operation == kbs_pkg::OP_ADD_EUC)
        begin
            code_sel = {1'b0, cmd.euc_lead[6:0], 1'b0, cmd.euc_trail[6:0]};
        end
        else
        begin
            code_sel = cmd.jis_code;
        end
        offset = code_sel - base_reg;
        loc_ok = (code_sel >= base_reg)
              && (offset[7:0] < 8'(kbs_pkg::CELLS))
              && (offset[15:8] < 8'(kbs_pkg::ROWS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= kbs_pkg::BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg       <= cmd.operation;
            code_reg     <= code_sel;
            euc_ok_reg   <= euc_ok;
            loc_ok_reg   <= loc_ok;
            low_text_reg <= (code_sel < kbs_pkg::TEXT_FLOOR);
            row_reg      <= loc_ok ? offset[8 +: kbs_pkg::ROW_W] : '0;
            cell_reg     <= loc_ok ? offset[kbs_pkg::CELL_W-1:0] : '0;
        end
    end

    // Row read for the current transaction.
    always_ff @(posedge clk)
    begin
        if (ctrl.read)
        begin
            rd_row_reg   <= member_mem[row_reg];
            rd_valid_reg <= row_valid_reg[row_reg];
        end
    end

    always_comb
    begin
        cur_bit      = loc_ok_reg & rd_valid_reg & rd_row_reg[cell_reg];
        set_bit      = 1'b0;
        clr_bit      = 1'b0;
        status_next  = kbs_pkg::ST_NO_CHANGE;
        present_next = 1'b0;
        decoded_next = '0;
        case (op_reg)
            kbs_pkg::OP_ADD, kbs_pkg::OP_ADD_EUC, kbs_pkg::OP_ADD_TEXT:
            begin
                if (op_reg == kbs_pkg::OP_ADD_EUC && !euc_ok_reg)
                begin
                    status_next = kbs_pkg::ST_NOT_EUC;
                end
                else
                begin
                    decoded_next = code_reg;
                    if (op_reg == kbs_pkg::OP_ADD_TEXT && low_text_reg)
                    begin
                        // Characters below the kanji range are skipped.
                        status_next  = kbs_pkg::ST_NO_CHANGE;
                        present_next = cur_bit;
                    end
                    else if (!loc_ok_reg)
                    begin
                        status_next = kbs_pkg::ST_RANGE;
                    end
                    else if (cur_bit)
                    begin
                        status_next  = kbs_pkg::ST_NO_CHANGE;
                        present_next = 1'b1;
                    end
                    else
                    begin
                        set_bit      = 1'b1;
                        status_next  = kbs_pkg::ST_DONE;
                        present_next = 1'b1;
                    end
                end
            end
            kbs_pkg::OP_REMOVE:
            begin
                decoded_next = code_reg;
                if (!loc_ok_reg)
                begin
                    status_next = kbs_pkg::ST_RANGE;
                end
                else if (!cur_bit)
                begin
                    status_next = kbs_pkg::ST_NO_CHANGE;
                end
                else
                begin
                    clr_bit     = 1'b1;
                    status_next = kbs_pkg::ST_DONE;
                end
            end
            kbs_pkg::OP_QUERY:
            begin
                decoded_next = code_reg;
                if (!loc_ok_reg)
                begin
                    status_next = kbs_pkg::ST_RANGE;
                end
                else
                begin
                    status_next  = kbs_pkg::ST_DONE;
                    present_next = cur_bit;
                end
            end
            kbs_pkg::OP_CLEAR:
            begin
                status_next = kbs_pkg::ST_DONE;
            end
            default:
            begin
                status_next = kbs_pkg::ST_NO_CHANGE;
            end
        endcase

        new_row           = rd_valid_reg ? rd_row_reg : '0;
        new_row[cell_reg] = set_bit;

        if (op_reg == kbs_pkg::OP_CLEAR)
        begin
            count_next = '0;
        end
        else if (set_bit)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (clr_bit)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update && (set_bit || clr_bit))
        begin
            member_mem[row_reg] <= new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.update;
            if (ctrl.update)
            begin
                count_reg <= count_next;
                if (op_reg == kbs_pkg::OP_CLEAR)
                begin
                    // Dropping every row flag empties the set without a sweep.
                    row_valid_reg <= '0;
                end
                else if (set_bit || clr_bit)
                begin
                    row_valid_reg[row_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            result_reg.status       <= status_next;
            result_reg.present      <= present_next;
            result_reg.member_count <= count_next;
            result_reg.decoded_code <= decoded_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
